/* hdl/u8d_pkg.sv */
`default_nettype none

package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned STAT_W = 2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_VALID   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_STRAY   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [CP_W-1:0]   code_point;
    logic [STAT_W-1:0] status;
  } u8d_result_t;

  typedef struct packed {
    logic [CNT_W-1:0] remaining;
  } u8d_dec_state_t;

endpackage

`default_nettype wire

/* hdl/u8d_decode.sv */
`default_nettype none

module u8d_decode (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        take,
  input  wire logic [u8d_pkg::BYTE_W-1:0]  data_byte,
  output u8d_pkg::u8d_result_t             result,
  output u8d_pkg::u8d_dec_state_t          dec_state
);

  logic [u8d_pkg::CNT_W-1:0] cnt_r;
  logic [u8d_pkg::CNT_W-1:0] cnt_nxt;
  logic [u8d_pkg::CP_W-1:0]  acc_r;
  logic [u8d_pkg::CP_W-1:0]  acc_nxt;
  u8d_pkg::u8d_result_t      res;

  always_comb begin
    res       = '0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    if (cnt_r != '0) begin
      // Inside a sequence every byte is a continuation byte; top bits are ignored.
      acc_nxt = {acc_r[u8d_pkg::CP_W-7:0], data_byte[5:0]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == u8d_pkg::CNT_W'(1)) begin
        res.valid      = 1'b1;
        res.code_point = acc_nxt;
        res.status     = u8d_pkg::STATUS_VALID;
      end
    end else if (!data_byte[7]) begin
      res.valid      = 1'b1;
      res.code_point = {{(u8d_pkg::CP_W-8){1'b0}}, data_byte};
      res.status     = u8d_pkg::STATUS_VALID;
    end else if (!data_byte[6]) begin
      res.valid      = 1'b1;
      res.code_point = {{(u8d_pkg::CP_W-6){1'b0}}, data_byte[5:0]};
      res.status     = u8d_pkg::STATUS_STRAY;
    end else if (!data_byte[5]) begin
      acc_nxt = {{(u8d_pkg::CP_W-5){1'b0}}, data_byte[4:0]};
      cnt_nxt = u8d_pkg::CNT_W'(1);
    end else if (!data_byte[4]) begin
      acc_nxt = {{(u8d_pkg::CP_W-4){1'b0}}, data_byte[3:0]};
      cnt_nxt = u8d_pkg::CNT_W'(2);
    end else if (!data_byte[3]) begin
      acc_nxt = {{(u8d_pkg::CP_W-3){1'b0}}, data_byte[2:0]};
      cnt_nxt = u8d_pkg::CNT_W'(3);
    end else if (!data_byte[2]) begin
      acc_nxt = {{(u8d_pkg::CP_W-2){1'b0}}, data_byte[1:0]};
      cnt_nxt = u8d_pkg::CNT_W'(4);
    end else if (!data_byte[1]) begin
      acc_nxt = {{(u8d_pkg::CP_W-1){1'b0}}, data_byte[0]};
      cnt_nxt = u8d_pkg::CNT_W'(5);
    end else begin
      res.valid      = 1'b1;
      res.code_point = '0;
      res.status     = u8d_pkg::STATUS_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      acc_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    result       = res;
    result.valid = res.valid & take;
  end

  assign dec_state.remaining = cnt_r;

endmodule

`default_nettype wire

/* hdl/u8d_out_reg.sv */
`default_nettype none

module u8d_out_reg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire u8d_pkg::u8d_result_t        result,
  output logic                             free,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [u8d_pkg::CP_W-1:0]         out_code_point,
  output logic [u8d_pkg::STAT_W-1:0]       out_status
);

  logic                        valid_r;
  logic [u8d_pkg::CP_W-1:0]    cp_r;
  logic [u8d_pkg::STAT_W-1:0]  status_r;

  // The register can take a new item when empty or when its item leaves now.
  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (result.valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      cp_r     <= result.code_point;
      status_r <= result.status;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_point = cp_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire

/* hdl/utf8_stream_decoder.sv */
// Byte-serial decoder for the original wide UTF-8 form (one to six bytes,
// code points up to 31 bits). One byte enters per cycle with no bubbles
// while the result side does not stall; a byte is held in the input
// register, and the result it finishes is held in the result register
// until taken. Lead bytes and continuation bytes that do not finish a
// sequence produce no item. Status 0 is a code point, 1 a stray
// continuation byte (its low six bits), 2 a 0xFE or 0xFF lead byte.
// Continuation bytes are not checked, and there is no timeout on a
// truncated sequence. A stall on the result side reaches in_stall in the
// same cycle.
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [u8d_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [u8d_pkg::CP_W-1:0]           out_code_point,
  output logic [u8d_pkg::STAT_W-1:0]         out_status
);

  logic                           in_valid_r;
  logic [u8d_pkg::BYTE_W-1:0]     in_byte_r;
  logic                           out_free;
  logic                           take;
  u8d_pkg::u8d_result_t           result;
  u8d_pkg::u8d_dec_state_t        dec_state;

  assign take     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  u8d_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_byte_r),
    .result    (result),
    .dec_state (dec_state)
  );

  u8d_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .result         (result),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_status     (out_status)
  );

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    dec_state.remaining <= u8d_pkg::CNT_W'(5))
    else $error("continuation count out of range");

  a_no_result_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (take && dec_state.remaining > u8d_pkg::CNT_W'(1)) |-> !result.valid)
    else $error("result emitted in the middle of a sequence");

  a_stray_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == u8d_pkg::STATUS_STRAY) |->
      (out_code_point[u8d_pkg::CP_W-1:6] == '0))
    else $error("stray continuation item carries more than six bits");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == u8d_pkg::STATUS_VALID || out_status == u8d_pkg::STATUS_STRAY ||
                   out_status == u8d_pkg::STATUS_INVALID))
    else $error("undefined status code on output");

endmodule

`default_nettype wire

/* tb/tb_utf8_stream_decoder.sv */
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

  localparam int unsigned NUM_BYTES  = 1300;
  localparam int unsigned IDLE_LIMIT = 1000;

  typedef struct {
    logic [u8d_pkg::BYTE_W-1:0] data;
    int unsigned                gap;
    bit                         drain;
  } stream_byte_t;

  typedef struct {
    logic [u8d_pkg::CP_W-1:0]   cp;
    logic [u8d_pkg::STAT_W-1:0] st;
  } decoded_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [u8d_pkg::BYTE_W-1:0]   in_data_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [u8d_pkg::CP_W-1:0]     out_code_point;
  logic [u8d_pkg::STAT_W-1:0]   out_status;

  stream_byte_t byte_queue[$];
  decoded_t     decoded_queue[$];

  // Decoder state mirrored from the block.
  logic [u8d_pkg::CNT_W-1:0] cont_left = '0;
  logic [u8d_pkg::CP_W-1:0]  cp_accum = '0;

  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          pause_next = 1'b0;
  int unsigned idle_gap = 0;
  int unsigned stall_left = 0;
  int unsigned next_stall;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned n_code_points = 0;
  int unsigned n_stray = 0;
  int unsigned n_invalid = 0;
  int unsigned errors = 0;
  decoded_t    want;

  utf8_stream_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_status     (out_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void decode_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
    decoded_t r;
    bit       has_result;
    has_result = 1'b0;
    r.cp = '0;
    r.st = u8d_pkg::STATUS_VALID;
    if (cont_left != 0) begin
      cp_accum = {cp_accum[u8d_pkg::CP_W-7:0], b[5:0]};
      cont_left = cont_left - 1'b1;
      if (cont_left == 0) begin
        r.cp = cp_accum;
        has_result = 1'b1;
      end
    end else if (b < 8'h80) begin
      r.cp = u8d_pkg::CP_W'(b);
      has_result = 1'b1;
    end else if (b < 8'hC0) begin
      r.cp = u8d_pkg::CP_W'(b[5:0]);
      r.st = u8d_pkg::STATUS_STRAY;
      has_result = 1'b1;
    end else if (b < 8'hE0) begin
      cp_accum = u8d_pkg::CP_W'(b[4:0]);
      cont_left = 3'd1;
    end else if (b < 8'hF0) begin
      cp_accum = u8d_pkg::CP_W'(b[3:0]);
      cont_left = 3'd2;
    end else if (b < 8'hF8) begin
      cp_accum = u8d_pkg::CP_W'(b[2:0]);
      cont_left = 3'd3;
    end else if (b < 8'hFC) begin
      cp_accum = u8d_pkg::CP_W'(b[1:0]);
      cont_left = 3'd4;
    end else if (b < 8'hFE) begin
      cp_accum = u8d_pkg::CP_W'(b[0]);
      cont_left = 3'd5;
    end else begin
      r.st = u8d_pkg::STATUS_INVALID;
      has_result = 1'b1;
    end
    if (has_result) decoded_queue.push_back(r);
  endfunction

  function automatic void add_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
    stream_byte_t s;
    s.data = b;
    s.gap = tx_calm ? 0 : $urandom_range(0, 4);
    s.drain = pause_next;
    pause_next = 1'b0;
    byte_queue.push_back(s);
  endfunction

  // A well-formed sequence of the given length with random payload; now and
  // then a continuation slot carries an arbitrary byte instead.
  function automatic void add_sequence(input int unsigned len);
    logic [u8d_pkg::BYTE_W-1:0] lead;
    int unsigned                i;
    case (len)
      1: lead = 8'($urandom_range(0, 8'h7F));
      2: lead = 8'hC0 | 8'($urandom_range(0, 8'h1F));
      3: lead = 8'hE0 | 8'($urandom_range(0, 8'h0F));
      4: lead = 8'hF0 | 8'($urandom_range(0, 8'h07));
      5: lead = 8'hF8 | 8'($urandom_range(0, 8'h03));
      default: lead = 8'hFC | 8'($urandom_range(0, 8'h01));
    endcase
    add_byte(lead);
    for (i = 1; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) add_byte(8'($urandom_range(0, 255)));
      else add_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
    end
  endfunction

  // Driver: presents the next byte once its gap has passed; a byte marked
  // for draining waits until every outstanding result has been seen.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= '0;
      idle_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data_byte);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() != 0 && idle_gap >= byte_queue[0].gap &&
            !(byte_queue[0].drain && decoded_queue.size() != 0)) begin
          in_valid <= 1'b1;
          in_data_byte <= byte_queue[0].data;
          void'(byte_queue.pop_front());
          idle_gap <= 0;
        end else begin
          in_valid <= 1'b0;
          idle_gap <= idle_gap + 1;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction and draws a
  // stall before taking the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      next_stall = stall_left;
      if (out_valid && !out_stall) begin
        if (decoded_queue.size() == 0) begin
          $display("%0t: unexpected result code_point=%h status=%0d",
                   $time, out_code_point, out_status);
          errors++;
        end else begin
          want = decoded_queue.pop_front();
          if (out_code_point !== want.cp) begin
            $display("%0t: code_point mismatch, expected %h, actual %h",
                     $time, want.cp, out_code_point);
            errors++;
          end
          if (out_status !== want.st) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.st, out_status);
            errors++;
          end
          case (want.st)
            u8d_pkg::STATUS_VALID:  n_code_points++;
            u8d_pkg::STATUS_STRAY:  n_stray++;
            default:                n_invalid++;
          endcase
        end
        next_stall = rx_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
      end
      out_stall <= (next_stall != 0);
      stall_left <= (next_stall != 0) ? next_stall - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Single-byte extremes, stray continuations and invalid leads.
    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte(8'h80);
    add_byte(8'hBF);
    add_byte(8'hFE);
    add_byte(8'hFF);
    // Overlong two-byte form, then three- and four-byte sequences.
    add_byte(8'hC0); add_byte(8'h80);
    add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC);
    add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
    // Five-byte sequence where lead bytes and ASCII arrive as continuations.
    add_byte(8'hF8); add_byte(8'hFF); add_byte(8'hFE); add_byte(8'hC0); add_byte(8'h41);
    // Six-byte sequence giving the largest code point.
    add_byte(8'hFD);
    repeat (5) add_byte(8'hBF);

    pause_next = 1'b1;
    while (byte_queue.size() < NUM_BYTES) begin
      if ($urandom_range(0, 249) == 0) pause_next = 1'b1;
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)));
      else add_sequence($urandom_range(1, 6));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes; checked %0d code points, %0d stray continuations, %0d invalid leads.",
             bytes_sent, n_code_points, n_stray, n_invalid);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/u8d_pkg.sv
hdl/u8d_decode.sv
hdl/u8d_out_reg.sv
hdl/utf8_stream_decoder.sv
tb/tb_utf8_stream_decoder.sv
